// ===== rtl/cha_pkg.sv =====
`timescale 1ns / 1ps
package cha_pkg;

  localparam int MAX_KEY_WORDS = 4;
  localparam int HASH_SHIFT = 3;
  localparam logic [11:0] MAX_KICKS_RESET = 12'd1024;
  localparam logic REQ_BUILD = 1'b0;
  localparam logic REQ_PROBE = 1'b1;

  typedef enum logic [2:0] {
    ST_INSERTED      = 3'd0,
    ST_AGGREGATED    = 3'd1,
    ST_OVERFLOW      = 3'd2,
    ST_PROBE_ABSENT  = 3'd3,
    ST_PROBE_PRESENT = 3'd4
  } status_t;

  typedef struct packed {
    logic        req_type;
    logic [31:0] key0;
    logic [31:0] key1;
    logic [31:0] key2;
    logic [31:0] count;
  } item_t;

  typedef struct packed {
    status_t     status;
    logic        emit;
    logic [31:0] count;
    logic [31:0] key0;
    logic [31:0] key1;
    logic [31:0] key2;
    logic        overflowed;
  } result_t;

  typedef struct packed {
    logic clearing;
    logic overflow;
  } back_stat_t;

  typedef logic [MAX_KEY_WORDS-1:0][31:0] key_arr_t;

  // key words past the three inputs read as zero
  function automatic key_arr_t key_words(item_t it);
    key_arr_t k;
    k[0] = it.key0;
    k[1] = it.key1;
    k[2] = it.key2;
    k[3] = 32'd0;
    return k;
  endfunction

endpackage

// ===== rtl/cha_ram.sv =====
`timescale 1ns / 1ps
module cha_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wa,
  input  logic [WIDTH-1:0]         wd,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] ra,
  output logic [WIDTH-1:0]         rd
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[wa] <= wd;
    end
    if (re) begin
      rd_r <= mem_r[ra];
    end
  end

  assign rd = rd_r;

endmodule

// ===== rtl/cha_fifo.sv =====
`timescale 1ns / 1ps
module cha_fifo #(
  parameter int WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  logic [WIDTH-1:0] mem_r [2];
  logic             wp_r;
  logic             rp_r;
  logic [1:0]       cnt_r;
  logic             do_push;
  logic             do_pop;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) begin
        mem_r[wp_r] <= wdata;
        wp_r        <= !wp_r;
      end
      if (do_pop) begin
        rp_r <= !rp_r;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

endmodule

// ===== rtl/cha_front.sv =====
`timescale 1ns / 1ps
module cha_front import cha_pkg::*; #(
  parameter int HALF_SIZE = 1024,
  parameter int KEY_WORDS = 3
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         hold,
  input  logic                         in_push,
  input  item_t                        in_item,
  output logic                         in_full,
  output logic                         q_push,
  output item_t                        q_item,
  output logic [$clog2(HALF_SIZE)-1:0] q_h1,
  output logic [$clog2(HALF_SIZE)-1:0] q_h2,
  input  logic                         q_full
);

  localparam int HB = $clog2(HALF_SIZE);
  localparam logic [1:0] LAST_STEP = 2'(KEY_WORDS - 1);

  typedef enum logic [1:0] {F_IDLE, F_HASH, F_PUSH} fstate_t;

  fstate_t     state_r;
  item_t       item_r;
  logic [1:0]  step_r;
  logic [31:0] a_r;
  logic [31:0] b_r;
  key_arr_t    kin;
  logic [31:0] word;
  logic [31:0] mix;
  logic [31:0] prod;
  logic [31:0] bmix;

  assign kin  = key_words(item_r);
  assign word = kin[step_r];
  assign mix  = word ^ (word >> HASH_SHIFT);
  assign prod = b_r * mix;
  assign bmix = b_r ^ (b_r >> HASH_SHIFT);

  assign in_full = (state_r != F_IDLE) || hold;
  assign q_push  = (state_r == F_PUSH) && !q_full;
  assign q_item  = item_r;
  assign q_h1    = a_r[HB-1:0];
  assign q_h2    = bmix[HB-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      unique case (state_r)
        F_IDLE: begin
          if (in_push && !in_full) begin
            item_r  <= in_item;
            a_r     <= 32'd0;
            b_r     <= 32'd1;
            step_r  <= 2'd0;
            state_r <= F_HASH;
          end
        end
        F_HASH: begin
          // one key word per cycle through the shared multiplier
          a_r    <= (a_r << 1) + word;
          b_r    <= prod;
          step_r <= step_r + 2'd1;
          if (step_r == LAST_STEP) begin
            state_r <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (!q_full) begin
            state_r <= F_IDLE;
          end
        end
        default: state_r <= F_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/cha_back.sv =====
`timescale 1ns / 1ps
module cha_back import cha_pkg::*; #(
  parameter int HALF_SIZE = 1024,
  parameter int KEY_WORDS = 3
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [11:0]                  max_kicks,
  input  logic                         q_valid,
  input  item_t                        q_item,
  input  logic [$clog2(HALF_SIZE)-1:0] q_h1,
  input  logic [$clog2(HALF_SIZE)-1:0] q_h2,
  output logic                         q_pop,
  output result_t                      res,
  output logic                         res_valid,
  input  logic                         res_pop,
  output back_stat_t                   stat
);

  localparam int HB = $clog2(HALF_SIZE);
  localparam int AW = HB + 1;
  localparam int KB = KEY_WORDS * 32;

  typedef struct packed {
    logic          valid;
    logic [HB-1:0] h1;
    logic [HB-1:0] h2;
    logic [31:0]   count;
    logic [KB-1:0] key;
  } entry_t;

  localparam int EW = $bits(entry_t);

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_LOOK1, S_LOOK2, S_KICK} bstate_t;

  bstate_t       state_r;
  logic [AW-1:0] clr_addr_r;
  item_t         item_r;
  logic [HB-1:0] h1_r;
  logic [HB-1:0] h2_r;
  logic          hit1_r;
  logic [31:0]   cnt1_r;
  entry_t        cur_r;
  logic          first_r;
  logic [11:0]   kick_r;
  logic          ovf_r;
  result_t       res_r;
  logic          res_valid_r;

  key_arr_t      kin;
  logic [KB-1:0] key_in;
  logic [EW-1:0] rd_data;
  entry_t        rd_ent;
  logic          match;
  logic [31:0]   old_cnt;
  logic [32:0]   sum;
  logic [31:0]   sat_cnt;
  logic [11:0]   kick_nxt;
  logic          we;
  logic [AW-1:0] wa;
  entry_t        wd;
  logic          re;
  logic [AW-1:0] ra;
  logic          fin_go;
  status_t       fin_status;
  logic          ovf_set;
  logic          fin_emit;

  assign kin = key_words(item_r);

  always_comb begin
    for (int i = 0; i < KEY_WORDS; i++) begin
      key_in[i*32 +: 32] = kin[i];
    end
  end

  assign rd_ent   = entry_t'(rd_data);
  assign match    = rd_ent.valid && (rd_ent.key == key_in);
  assign old_cnt  = hit1_r ? cnt1_r : rd_ent.count;
  assign sum      = {1'b0, old_cnt} + {1'b0, item_r.count};
  assign sat_cnt  = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
  assign kick_nxt = kick_r + 12'd1;
  assign q_pop    = (state_r == S_IDLE) && q_valid && !res_valid_r;

  always_comb begin
    we         = 1'b0;
    wa         = '0;
    wd         = '0;
    re         = 1'b0;
    ra         = '0;
    fin_go     = 1'b0;
    fin_status = ST_INSERTED;
    ovf_set    = 1'b0;
    case (state_r)
      S_CLEAR: begin
        we = 1'b1;
        wa = clr_addr_r;
      end
      S_IDLE: begin
        re = q_pop;
        ra = {1'b0, q_h1};
      end
      S_LOOK1: begin
        re = 1'b1;
        ra = {1'b1, h2_r};
      end
      S_LOOK2: begin
        if (item_r.req_type == REQ_PROBE) begin
          fin_go     = 1'b1;
          fin_status = (hit1_r || match) ? ST_PROBE_PRESENT : ST_PROBE_ABSENT;
        end else if (hit1_r || match) begin
          we         = 1'b1;
          wa         = hit1_r ? {1'b0, h1_r} : {1'b1, h2_r};
          wd         = '{valid: 1'b1, h1: h1_r, h2: h2_r, count: sat_cnt, key: key_in};
          fin_go     = 1'b1;
          fin_status = ST_AGGREGATED;
        end else if (max_kicks == 12'd0) begin
          ovf_set    = 1'b1;
          fin_go     = 1'b1;
          fin_status = ST_OVERFLOW;
        end else begin
          re = 1'b1;
          ra = {1'b0, h1_r};
        end
      end
      S_KICK: begin
        // place the entry in hand; the next slot lies in the other half
        we = 1'b1;
        wa = first_r ? {1'b0, cur_r.h1} : {1'b1, cur_r.h2};
        wd = cur_r;
        if (!rd_ent.valid) begin
          fin_go     = 1'b1;
          fin_status = ST_INSERTED;
        end else if (kick_nxt == max_kicks) begin
          ovf_set    = 1'b1;
          fin_go     = 1'b1;
          fin_status = ST_OVERFLOW;
        end else begin
          re = 1'b1;
          ra = first_r ? {1'b1, rd_ent.h2} : {1'b0, rd_ent.h1};
        end
      end
      default: ;
    endcase
  end

  assign fin_emit = (fin_status == ST_PROBE_ABSENT);

  cha_ram #(
    .WIDTH (EW),
    .DEPTH (2 * HALF_SIZE)
  ) u_table (
    .clk (clk),
    .we  (we),
    .wa  (wa),
    .wd  (wd),
    .re  (re),
    .ra  (ra),
    .rd  (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      ovf_r       <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      if (res_pop && res_valid_r) begin
        res_valid_r <= 1'b0;
      end
      if (ovf_set) begin
        ovf_r <= 1'b1;
      end
      if (fin_go) begin
        res_r.status     <= fin_status;
        res_r.emit       <= fin_emit;
        res_r.count      <= fin_emit ? item_r.count : 32'd0;
        res_r.key0       <= item_r.key0;
        res_r.key1       <= item_r.key1;
        res_r.key2       <= item_r.key2;
        res_r.overflowed <= ovf_r || ovf_set;
        res_valid_r      <= 1'b1;
        state_r          <= S_IDLE;
      end
      unique case (state_r)
        S_CLEAR: begin
          clr_addr_r <= clr_addr_r + AW'(1);
          if (clr_addr_r == {AW{1'b1}}) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (q_pop) begin
            item_r  <= q_item;
            h1_r    <= q_h1;
            h2_r    <= q_h2;
            state_r <= S_LOOK1;
          end
        end
        S_LOOK1: begin
          hit1_r  <= match;
          cnt1_r  <= rd_ent.count;
          state_r <= S_LOOK2;
        end
        S_LOOK2: begin
          if (!fin_go) begin
            cur_r   <= '{valid: 1'b1, h1: h1_r, h2: h2_r, count: item_r.count,
                         key: key_in};
            first_r <= 1'b1;
            kick_r  <= 12'd0;
            state_r <= S_KICK;
          end
        end
        S_KICK: begin
          if (!fin_go) begin
            cur_r   <= rd_ent;
            first_r <= !first_r;
            kick_r  <= kick_nxt;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign res           = res_r;
  assign res_valid     = res_valid_r;
  assign stat.clearing = (state_r == S_CLEAR);
  assign stat.overflow = ovf_r;

endmodule

// ===== rtl/cuckoo_hash_anti_join.sv =====
`timescale 1ns / 1ps
// Hash anti-join on a two-half cuckoo hash set. After reset all 2*HALF_SIZE table
// entries are swept clear with in_full held high. The front hashes one key word
// per cycle through a single 32x32 multiplier and takes one request at a time;
// a two-entry queue feeds the back, which uses one table memory with one read
// and one write port: a lookup takes two reads, and a new key may need cuckoo
// placements, up to max_kicks. One result per request, in order; a result waits
// in an output register.
module cuckoo_hash_anti_join import cha_pkg::*; #(
  parameter int HALF_SIZE = 1024,
  parameter int KEY_WORDS = 3
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [11:0] cfg_max_kicks,
  input  logic        push,
  output logic        full,
  input  logic        in_req_type,
  input  logic [31:0] in_key_word0,
  input  logic [31:0] in_key_word1,
  input  logic [31:0] in_key_word2,
  input  logic [31:0] in_tuple_count,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  out_status,
  output logic        out_emit,
  output logic [31:0] out_count,
  output logic [31:0] out_key0,
  output logic [31:0] out_key1,
  output logic [31:0] out_key2,
  output logic        out_overflowed
);

  localparam int HB = $clog2(HALF_SIZE);
  localparam int QW = $bits(item_t) + 2 * HB;

  logic [11:0]   max_kicks_r;
  item_t         in_item;
  logic          q_push;
  item_t         f_item;
  logic [HB-1:0] f_h1;
  logic [HB-1:0] f_h2;
  logic          q_full;
  logic          q_empty;
  logic [QW-1:0] q_rdata;
  item_t         b_item;
  logic [HB-1:0] b_h1;
  logic [HB-1:0] b_h2;
  logic          q_pop;
  result_t       res;
  logic          res_valid;
  back_stat_t    bstat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_kicks_r <= MAX_KICKS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_kicks_r <= cfg_max_kicks;
    end
  end

  assign in_item = '{req_type: in_req_type, key0: in_key_word0, key1: in_key_word1,
                     key2: in_key_word2, count: in_tuple_count};

  cha_front #(
    .HALF_SIZE (HALF_SIZE),
    .KEY_WORDS (KEY_WORDS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .hold    (bstat.clearing),
    .in_push (push),
    .in_item (in_item),
    .in_full (full),
    .q_push  (q_push),
    .q_item  (f_item),
    .q_h1    (f_h1),
    .q_h2    (f_h2),
    .q_full  (q_full)
  );

  cha_fifo #(
    .WIDTH (QW)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata ({f_item, f_h1, f_h2}),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  assign {b_item, b_h1, b_h2} = q_rdata;

  cha_back #(
    .HALF_SIZE (HALF_SIZE),
    .KEY_WORDS (KEY_WORDS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .max_kicks (max_kicks_r),
    .q_valid   (!q_empty),
    .q_item    (b_item),
    .q_h1      (b_h1),
    .q_h2      (b_h2),
    .q_pop     (q_pop),
    .res       (res),
    .res_valid (res_valid),
    .res_pop   (pop),
    .stat      (bstat)
  );

  assign empty          = !res_valid;
  assign out_status     = res.status;
  assign out_emit       = res.emit;
  assign out_count      = res.count;
  assign out_key0       = res.key0;
  assign out_key1       = res.key1;
  assign out_key2       = res.key2;
  assign out_overflowed = res.overflowed;

`ifndef SYNTHESIS
  a_ovf_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $past(bstat.overflow) |-> bstat.overflow)
    else $error("overflow flag dropped");

  a_emit_absent: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (out_emit == (out_status == ST_PROBE_ABSENT)))
    else $error("emit disagrees with status");

  a_ovf_result: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && (out_status == ST_OVERFLOW) |-> out_overflowed)
    else $error("lost entry without overflow flag");
`endif

endmodule

// ===== dv/cuckoo_hash_anti_join_tb.sv =====
`timescale 1ns / 1ps
module cuckoo_hash_anti_join_tb;
  import cha_pkg::*;

  localparam int HALF = 1024;
  localparam int SLOTS = 2 * HALF;
  localparam int LIMIT = 5000000;
  localparam int HOLD_CYCLES = 300;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [11:0] cfg_max_kicks = '0;
  logic        push = 1'b0;
  logic        full;
  logic        in_req_type = 1'b0;
  logic [31:0] in_key_word0 = '0;
  logic [31:0] in_key_word1 = '0;
  logic [31:0] in_key_word2 = '0;
  logic [31:0] in_tuple_count = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [2:0]  out_status;
  logic        out_emit;
  logic [31:0] out_count;
  logic [31:0] out_key0;
  logic [31:0] out_key1;
  logic [31:0] out_key2;
  logic        out_overflowed;

  cuckoo_hash_anti_join DUT (.*);

  always #10 clk = ~clk;

  // shadow of the hash set
  logic [95:0] set_key [SLOTS];
  logic [31:0] set_count [SLOTS];
  logic        set_valid [SLOTS];
  logic        lost_flag;
  logic [11:0] kick_limit;

  item_t       pending_q [$];
  result_t     expected_q [$];
  item_t       cur_req;
  logic [95:0] key_pool [48];

  int  errors = 0;
  int  cycles = 0;
  int  accepted = 0;
  int  checked = 0;
  int  overflows = 0;
  int  evict_builds = 0;
  bit  calm = 1'b0;
  bit  hold_go = 1'b0;
  bit  hold_done = 1'b0;
  int  hold_left = 0;

  function automatic int slot_lo(logic [95:0] k);
    logic [31:0] a;
    a = 32'd0;
    for (int i = 0; i < 3; i++) a = (a << 1) + k[32*i +: 32];
    return int'(a & (HALF - 1));
  endfunction

  function automatic int slot_hi(logic [95:0] k);
    logic [31:0] b;
    logic [31:0] w;
    b = 32'd1;
    for (int i = 0; i < 3; i++) begin
      w = k[32*i +: 32];
      b = b * (w ^ (w >> HASH_SHIFT));
    end
    return HALF + int'((b ^ (b >> HASH_SHIFT)) & (HALF - 1));
  endfunction

  function automatic result_t join_request(item_t it);
    result_t     r;
    logic [95:0] k;
    logic [95:0] hand_key;
    logic [95:0] tmp_key;
    logic [31:0] hand_cnt;
    logic [31:0] tmp_cnt;
    logic [32:0] sum;
    int          s1;
    int          s2;
    int          hit;
    int          s;
    bit          use_lo;
    bit          placed;
    k = {it.key2, it.key1, it.key0};
    s1 = slot_lo(k);
    s2 = slot_hi(k);
    hit = -1;
    if (set_valid[s1] && set_key[s1] == k) hit = s1;
    else if (set_valid[s2] && set_key[s2] == k) hit = s2;
    r.emit = 1'b0;
    r.count = '0;
    if (it.req_type == REQ_BUILD) begin
      if (hit >= 0) begin
        sum = {1'b0, set_count[hit]} + {1'b0, it.count};
        set_count[hit] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        r.status = ST_AGGREGATED;
      end else begin
        hand_key = k;
        hand_cnt = it.count;
        use_lo = 1'b1;
        placed = 1'b0;
        for (int n = 0; n < int'(kick_limit) && !placed; n++) begin
          s = use_lo ? slot_lo(hand_key) : slot_hi(hand_key);
          if (!set_valid[s]) begin
            set_key[s] = hand_key;
            set_count[s] = hand_cnt;
            set_valid[s] = 1'b1;
            placed = 1'b1;
          end else begin
            tmp_key = set_key[s];
            tmp_cnt = set_count[s];
            set_key[s] = hand_key;
            set_count[s] = hand_cnt;
            hand_key = tmp_key;
            hand_cnt = tmp_cnt;
            use_lo = !use_lo;
            if (n == 0) evict_builds++;
          end
        end
        if (placed) r.status = ST_INSERTED;
        else begin
          lost_flag = 1'b1;
          overflows++;
          r.status = ST_OVERFLOW;
        end
      end
    end else if (hit >= 0) begin
      r.status = ST_PROBE_PRESENT;
    end else begin
      r.status = ST_PROBE_ABSENT;
      r.emit = 1'b1;
      r.count = it.count;
    end
    r.key0 = it.key0;
    r.key1 = it.key1;
    r.key2 = it.key2;
    r.overflowed = lost_flag;
    return r;
  endfunction

  function automatic item_t make_req(logic req, logic [95:0] k, logic [31:0] c);
    item_t it;
    it.req_type = req;
    it.key0 = k[31:0];
    it.key1 = k[63:32];
    it.key2 = k[95:64];
    it.count = c;
    return it;
  endfunction

  function automatic void queue_req(item_t it);
    pending_q = {pending_q, it};
  endfunction

  function automatic item_t random_req();
    logic [95:0] k;
    logic [31:0] c;
    int          pick;
    pick = $urandom_range(99);
    if (pick < 55) k = key_pool[$urandom_range(47)];
    else if (pick < 75) begin
      // same first slot as a pool key
      k = key_pool[$urandom_range(47)];
      k[95:64] = k[95:64] + 32'd1024 * $urandom_range(1, 15);
      k[63:32] = k[63:32] - 32'd2048 * $urandom_range(1, 3);
    end else k = {$urandom, $urandom, $urandom};
    pick = $urandom_range(99);
    if (pick < 8) c = 32'd0;
    else if (pick < 20) c = 32'hFFFF_FFFF - $urandom_range(3);
    else c = $urandom;
    return make_req(logic'($urandom_range(1)), k, c);
  endfunction

  // driver
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst_n) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        expected_q = {expected_q, join_request(cur_req)};
        accepted++;
      end
      if (!(push && full)) begin
        if (pending_q.size() > 0 && (calm || $urandom_range(99) >= 27)) begin
          cur_req = pending_q.pop_front();
          push <= 1'b1;
          in_req_type <= cur_req.req_type;
          in_key_word0 <= cur_req.key0;
          in_key_word1 <= cur_req.key1;
          in_key_word2 <= cur_req.key2;
          in_tuple_count <= cur_req.count;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    result_t e;
    if (rst_n) begin
      if (pop && !empty) begin
        checked++;
        if (expected_q.size() == 0) begin
          $error("result with nothing expected: status %0d key0 %h", out_status, out_key0);
          errors++;
        end else begin
          e = expected_q.pop_front();
          if (out_status !== e.status) begin
            $error("status expected %0d got %0d", e.status, out_status); errors++;
          end
          if (out_emit !== e.emit) begin
            $error("emit expected %0d got %0d", e.emit, out_emit); errors++;
          end
          if (out_count !== e.count) begin
            $error("out_count expected %h got %h", e.count, out_count); errors++;
          end
          if (out_key0 !== e.key0) begin
            $error("out_key0 expected %h got %h", e.key0, out_key0); errors++;
          end
          if (out_key1 !== e.key1) begin
            $error("out_key1 expected %h got %h", e.key1, out_key1); errors++;
          end
          if (out_key2 !== e.key2) begin
            $error("out_key2 expected %h got %h", e.key2, out_key2); errors++;
          end
          if (out_overflowed !== e.overflowed) begin
            $error("overflowed expected %0d got %0d", e.overflowed, out_overflowed);
            errors++;
          end
        end
      end
      if (hold_go && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= calm || ($urandom_range(99) >= 27);
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic write_kicks(logic [11:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_max_kicks <= v;
    do @(posedge clk); while (!cfg_ready);
    kick_limit = v;
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (!(pending_q.size() == 0 && !push && expected_q.size() == 0)) @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  initial begin
    logic [95:0] k;
    logic [11:0] kick_set [6];
    for (int i = 0; i < SLOTS; i++) begin
      set_valid[i] = 1'b0;
      set_key[i] = '0;
      set_count[i] = '0;
    end
    lost_flag = 1'b0;
    kick_limit = MAX_KICKS_RESET;
    for (int i = 0; i < 48; i++) begin
      key_pool[i] = {$urandom, $urandom, $urandom};
      // groups of eight share the first slot
      if (i % 8 != 0) key_pool[i] = key_pool[i - 1] + {32'd1024, 64'd0};
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty-table probe, extremes, saturation, eviction
    k = {32'h0000_0005, 32'h0000_0007, 32'h0000_0009};
    queue_req(make_req(REQ_PROBE, '0, 32'd0));
    queue_req(make_req(REQ_BUILD, '0, 32'd0));
    queue_req(make_req(REQ_PROBE, '0, 32'd5));
    queue_req(make_req(REQ_BUILD, '1, 32'hFFFF_FFFF));
    queue_req(make_req(REQ_BUILD, '1, 32'd1));
    queue_req(make_req(REQ_PROBE, '1, 32'hFFFF_FFFF));
    queue_req(make_req(REQ_BUILD, '0, 32'd3));
    queue_req(make_req(REQ_BUILD, k, 32'd10));
    queue_req(make_req(REQ_BUILD, k + {32'd1024, 64'd0}, 32'd20));
    queue_req(make_req(REQ_BUILD, k + {32'd2048, 64'd0}, 32'd30));
    queue_req(make_req(REQ_PROBE, k, 32'd1));
    queue_req(make_req(REQ_PROBE, k + {32'd1024, 64'd0}, 32'd1));
    queue_req(make_req(REQ_PROBE, k + {32'd4096, 64'd0}, 32'h8000_0000));
    queue_req(make_req(REQ_PROBE, {32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555},
                       32'hAAAA_AAAA));
    drain();

    // one placement only: a first-slot collision loses an entry
    write_kicks(12'd1);
    queue_req(make_req(REQ_BUILD, k + {32'd3072, 64'd0}, 32'd7));
    queue_req(make_req(REQ_PROBE, k + {32'd3072, 64'd0}, 32'd7));
    drain();
    write_kicks(12'd0);
    queue_req(make_req(REQ_BUILD, {32'd1, 32'd2, 32'd3}, 32'd4));
    queue_req(make_req(REQ_PROBE, {32'd1, 32'd2, 32'd3}, 32'd4));
    drain();

    kick_set = '{12'd1024, 12'd1, 12'd4095, 12'd0, 12'd2048, 12'd3};
    for (int ph = 0; ph < 6; ph++) begin
      write_kicks(kick_set[ph]);
      calm = (ph == 2);
      if (ph == 1) hold_go = 1'b1;
      for (int n = 0; n < 100; n++) queue_req(random_req());
      drain();
    end
    calm = 1'b0;
    repeat (50) @(posedge clk);
    if (expected_q.size() != 0) begin
      $error("%0d results never arrived", expected_q.size());
      errors++;
    end
    $display("Ran %0d requests through six eviction limits, %0d results checked.",
             accepted, checked);
    $display("Builds that evicted: %0d, builds that lost an entry: %0d.",
             evict_builds, overflows);
    if (errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
